### design/sbm_pkg.sv
// Shared types and fixed field widths for the SAD block-matching stereo block.
package sbm_pkg;

	localparam int PIX_W        = 8;
	localparam int DISP_W       = 6;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 8;
	localparam int OUT_TUSER_W  = 2;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int CFG_DATA_W   = 12;
	localparam int ROW_W        = 13;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic cost_start;
		logic emit_start;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic loop_done;
		logic center_valid;
		logic has_results;
		logic last_result;
		logic out_free;
	} stat_t;

endpackage

### design/sbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/sbm_ctrl.sv
// Sequencing state machine: accept, column-cost pass, per-result WTA pass, output load.
module sbm_ctrl
	import sbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output cmd_t  cmd,
	input  stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CSTART,
		ST_CWAIT,
		ST_ESTART,
		ST_EWAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == ST_IDLE) && s_tvalid;
		cmd.cost_start = (state_q == ST_CSTART);
		cmd.emit_start = (state_q == ST_ESTART);
		cmd.load_out   = (state_q == ST_OUT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= stat.center_valid ? ST_CSTART : ST_IDLE;
				end
				ST_CSTART: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (stat.loop_done) state_q <= stat.has_results ? ST_ESTART : ST_IDLE;
				end
				ST_ESTART: state_q <= ST_EWAIT;
				ST_EWAIT: begin
					if (stat.loop_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (stat.out_free) state_q <= stat.last_result ? ST_IDLE : ST_ESTART;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/sbm_datapath.sv
// Line stores, column-cost RAMs, disparity sweep, WTA compare and output register.
module sbm_datapath
	import sbm_pkg::*;
#(
	parameter int MAX_DISPARITY = 64,
	parameter int WINDOW_HEIGHT = 5,
	parameter int WINDOW_WIDTH  = 5,
	parameter int MAX_LINE      = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser,
	output logic                   m_tlast,
	input  cmd_t                   cmd,
	output stat_t                  stat
);

	localparam int HH     = WINDOW_HEIGHT / 2;
	localparam int HW     = WINDOW_WIDTH / 2;
	localparam int SPAN_H = 2 * HH + 1;
	localparam int SPAN_W = 2 * HW + 1;
	localparam int LW     = $clog2(MAX_LINE);
	localparam int WW     = LW + 1;
	localparam int DW     = $clog2(MAX_DISPARITY);
	localparam int RSW    = (SPAN_H > 1) ? $clog2(SPAN_H) : 1;
	localparam int CSW    = (SPAN_W > 1) ? $clog2(SPAN_W) : 1;
	localparam int CW     = $clog2(SPAN_H * 255 + 1);
	localparam int SW     = $clog2(SPAN_W * SPAN_H * 255 + 1);

	// configuration and frame position
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WW-1:0]           w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [LW-1:0]           col_q;
	logic [ROW_W-1:0]        row_q;
	logic [RSW-1:0]          rslot_q;
	logic [CSW-1:0]          cslot_q;
	logic                    col_last;
	logic [LW-1:0]           lo_c;
	logic [CSW-1:0]          lo_slot;

	// latched item position
	logic [LW-1:0]    cur_c_q;
	logic [ROW_W-1:0] cur_r_q;
	logic [RSW-1:0]   cur_rs_q;
	logic [CSW-1:0]   cur_cs_q;
	logic             cur_last_col_q;
	logic [LW-1:0]    hi_q;
	logic             has_res_q;
	logic [LW-1:0]    j_q;
	logic [CSW-1:0]   jslot_q;

	// disparity sweep
	logic          iss_q;
	logic          mode_q;
	logic [DW-1:0] d_q;
	logic          vld_s1;
	logic [DW-1:0] d_s1;
	logic          rin_s1;
	logic          rin;
	logic [LW-1:0] line_raddr;

	logic [2*PIX_W-1:0] line_rd [SPAN_H];
	logic [PIX_W-1:0]   left_q  [SPAN_H];
	logic [CW-1:0]      col_rd  [SPAN_W];
	logic [SPAN_H-1:0]  row_ok;
	logic [SPAN_W-1:0]  col_ok;
	logic [CW-1:0]      col_sum;
	logic [SW-1:0]      win_sum;
	logic [SW-1:0]      best_q;
	logic [DW-1:0]      best_d_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;
	logic                   m_tlast_q;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_q) > MAX_LINE) begin
			w_eff = WW'(MAX_LINE);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
	end

	assign col_last = (WW'(col_q) + WW'(1)) >= w_eff;
	assign lo_c     = (int'(col_q) >= HW) ? LW'(int'(col_q) - HW) : '0;
	// slot of column lo, at most HW behind the current column's slot
	assign lo_slot  = (int'(cslot_q) >= int'(col_q - lo_c)) ?
		CSW'(int'(cslot_q) - int'(col_q - lo_c)) :
		CSW'(int'(cslot_q) + SPAN_W - int'(col_q - lo_c));

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(640);
			height_q <= HEIGHT_REG_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			rslot_q  <= '0;
			cslot_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= WIDTH_REG_W'(cfg_wdata);
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			rslot_q <= '0;
			cslot_q <= '0;
		end else if (cmd.accept) begin
			if (col_last) begin
				col_q   <= '0;
				cslot_q <= '0;
				if ((row_q + ROW_W'(1)) >= (ROW_W'(h_eff) + ROW_W'(HH))) begin
					row_q   <= '0;
					rslot_q <= '0;
				end else begin
					row_q   <= row_q + ROW_W'(1);
					rslot_q <= (int'(rslot_q) == SPAN_H - 1) ? '0 : rslot_q + RSW'(1);
				end
			end else begin
				col_q   <= col_q + LW'(1);
				cslot_q <= (int'(cslot_q) == SPAN_W - 1) ? '0 : cslot_q + CSW'(1);
			end
		end
	end

	// item position and result walk
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_c_q        <= col_q;
			cur_r_q        <= row_q;
			cur_rs_q       <= rslot_q;
			cur_cs_q       <= cslot_q;
			cur_last_col_q <= col_last;
			hi_q           <= col_last ? col_q : lo_c;
			has_res_q      <= col_last || (int'(col_q) >= HW);
			j_q            <= lo_c;
			jslot_q        <= lo_slot;
		end else if (cmd.load_out) begin
			j_q     <= j_q + LW'(1);
			jslot_q <= (int'(jslot_q) == SPAN_W - 1) ? '0 : jslot_q + CSW'(1);
		end
	end

	// sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 1'b0;
			mode_q <= 1'b0;
			d_q    <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= iss_q;
			if (cmd.cost_start || cmd.emit_start) begin
				iss_q  <= 1'b1;
				mode_q <= cmd.emit_start;
				d_q    <= '0;
			end else if (iss_q) begin
				d_q <= d_q + DW'(1);
				if (d_q == DW'(MAX_DISPARITY - 1)) iss_q <= 1'b0;
			end
		end
	end

	assign rin        = int'(cur_c_q) >= int'(d_q);
	assign line_raddr = rin ? LW'(int'(cur_c_q) - int'(d_q)) : '0;

	always_ff @(posedge clk) begin
		d_s1   <= d_q;
		rin_s1 <= rin;
	end

	// line stores, one RAM per row slot: {right, left}
	for (genvar s = 0; s < SPAN_H; s++) begin : g_line
		sbm_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_LINE)) u_line (
			.clk  (clk),
			.we   (cmd.accept && (int'(rslot_q) == s)),
			.waddr(col_q),
			.wdata(s_tuser ? '0 : s_tdata),
			.raddr(line_raddr),
			.rdata(line_rd[s])
		);

		always_ff @(posedge clk) begin
			if (vld_s1 && !mode_q && (d_s1 == '0)) left_q[s] <= line_rd[s][PIX_W-1:0];
		end
	end

	// rows of the window that lie inside the image
	always_comb begin
		row_ok = '0;
		for (int k = 0; k < SPAN_H; k++) begin
			if ((int'(cur_r_q) >= k) && ((int'(cur_r_q) - k) < int'(h_eff))) begin
				row_ok[(int'(cur_rs_q) >= k) ? RSW'(int'(cur_rs_q) - k) :
					RSW'(int'(cur_rs_q) + SPAN_H - k)] = 1'b1;
			end
		end
	end

	always_comb begin
		logic [PIX_W-1:0] lv;
		logic [PIX_W-1:0] rv;
		col_sum = '0;
		for (int s = 0; s < SPAN_H; s++) begin
			lv = (d_s1 == '0) ? line_rd[s][PIX_W-1:0] : left_q[s];
			rv = rin_s1 ? line_rd[s][2*PIX_W-1:PIX_W] : '0;
			if (row_ok[s]) col_sum = col_sum + CW'((lv > rv) ? (lv - rv) : (rv - lv));
		end
	end

	// column-cost RAMs, one per column slot, addressed by disparity
	for (genvar t = 0; t < SPAN_W; t++) begin : g_col
		sbm_ram #(.WIDTH(CW), .DEPTH(MAX_DISPARITY)) u_col (
			.clk  (clk),
			.we   (vld_s1 && !mode_q && (int'(cur_cs_q) == t)),
			.waddr(d_s1),
			.wdata(col_sum),
			.raddr(d_q),
			.rdata(col_rd[t])
		);
	end

	// columns of the window that lie inside the row
	always_comb begin
		int x;
		int sl;
		col_ok = '0;
		for (int k = 0; k < SPAN_W; k++) begin
			x  = int'(j_q) - HW + k;
			sl = int'(jslot_q) - HW + k;
			if (sl < 0) sl = sl + SPAN_W;
			else if (sl >= SPAN_W) sl = sl - SPAN_W;
			if ((x >= 0) && (x <= int'(cur_c_q))) col_ok[CSW'(sl)] = 1'b1;
		end
	end

	always_comb begin
		win_sum = '0;
		for (int t = 0; t < SPAN_W; t++) begin
			if (col_ok[t]) win_sum = win_sum + SW'(col_rd[t]);
		end
	end

	// winner-take-all, strict less keeps the smaller disparity on a tie
	always_ff @(posedge clk) begin
		if (vld_s1 && mode_q && ((d_s1 == '0) || (win_sum < best_q))) begin
			best_q   <= win_sum;
			best_d_q <= d_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q    <= OUT_TDATA_W'(DISP_W'(best_d_q));
			m_tuser_q[0] <= cur_last_col_q && (j_q == hi_q);
			m_tuser_q[1] <= cur_last_col_q && (j_q == hi_q) &&
				(cur_r_q == (ROW_W'(h_eff) - ROW_W'(1) + ROW_W'(HH)));
			m_tlast_q    <= (j_q == hi_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		stat              = '0;
		stat.loop_done    = !iss_q && !vld_s1;
		stat.center_valid = (int'(cur_r_q) >= HH) && ((int'(cur_r_q) - HH) < int'(h_eff));
		stat.has_results  = has_res_q;
		stat.last_result  = (j_q == hi_q);
		stat.out_free     = !m_tvalid_q || m_tready;
	end

endmodule

### design/stereo_sad_block_matching_wta.sv
// Top level of the SAD block-matching stereo disparity block.
//
// Left/right pixel pairs stream in raster order, one transaction per pixel,
// followed by WINDOW_HEIGHT/2 pad rows per frame to flush the bottom. Each
// transaction writes the pixel pair into a row-slot line store. Once the
// window's center row exists, one sweep over all MAX_DISPARITY disparities
// reads every row slot at column c-d and stores the column SAD per
// disparity. Then each result (output pixel c-WINDOW_WIDTH/2, plus the rest
// of the row on the row's last column) takes a second sweep that reads the
// column-cost RAMs at every disparity, sums the window and keeps the lowest
// cost, smaller disparity on a tie. A transaction with no centered row
// skips both passes; otherwise it takes the column pass and then one
// sweep per result, each sweep reading the line-store or column-cost RAM
// ports at one read per cycle; a row end has up to 1 + WINDOW_WIDTH/2
// results. No new transaction is taken before the results of the last
// are loaded. A finished result sits in the output register while the next
// input transaction is taken. No clearing pass after reset: every store
// entry is written before it is read. A configuration write restarts the
// frame at row 0, column 0.
module stereo_sad_block_matching_wta
	import sbm_pkg::*;
#(
	parameter int MAX_DISPARITY = 64,
	parameter int WINDOW_HEIGHT = 5,
	parameter int WINDOW_WIDTH  = 5,
	parameter int MAX_LINE      = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: index 0 image_width, 1 image_height
	input  logic                   cfg_wr_en,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] left_pixel, [15:8] right_pixel
	input  logic                   s_tuser,   // [0] pad
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] disparity, [7:6] zero
	output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] row_end, [1] frame_end
	output logic                   m_tlast    // last result of the input transaction
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	sbm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	// storage, arithmetic and output register
	sbm_datapath #(
		.MAX_DISPARITY(MAX_DISPARITY),
		.WINDOW_HEIGHT(WINDOW_HEIGHT),
		.WINDOW_WIDTH (WINDOW_WIDTH),
		.MAX_LINE     (MAX_LINE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

### design/sbm_checker.sv
// Port-level assertions for the stereo block, bound to the top level.
module sbm_checker
	import sbm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic                   m_tlast
);

	// one pixel at a time: busy right after an input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted back to back");

	// frame end only on a row end
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("frame_end without row_end");

	// a row end is always the final result of its input transaction
	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("row_end on a non-final result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast)))
		else $error("stalled result changed");

endmodule

bind stereo_sad_block_matching_wta sbm_checker u_sbm_checker (.*);
